>>> sv/sbc_pkg.sv
// ----------------------------------------------------------------------------
// Swept box contact package
// Shared types and constants for the swept box contact unit.
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int TIME_W = 48;

	typedef enum logic [1:0] {
		STATUS_MISS    = 2'd0,
		STATUS_HIT     = 2'd1,
		STATUS_OVERLAP = 2'd2
	} status_t;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Z = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	localparam logic [1:0] SIGN_ZERO = 2'b00;
	localparam logic [1:0] SIGN_POS  = 2'b01;
	localparam logic [1:0] SIGN_NEG  = 2'b11;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_AXIS,
		ST_DIV_A,
		ST_WAIT_A,
		ST_DIV_B,
		ST_WAIT_B,
		ST_UPDATE,
		ST_STATUS,
		ST_MUL,
		ST_END,
		ST_CONTACT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
		logic busy;
	} div_ctl_t;

endpackage

>>> sv/swept_box_contact_unit.sv
// ----------------------------------------------------------------------------
// Swept box contact unit
// Slab test of a moving box against a static box, with entry time, normal,
// contact coordinate and moved span for each axis.
// ----------------------------------------------------------------------------
// An x or y request is stored. A z request is stored and starts the test:
// unless the boxes already overlap or a separating axis is found, each
// axis with non-zero velocity runs two divides on the shared divider, and
// each of the three results then passes ST_MUL, ST_END and ST_CONTACT and
// waits in ST_OUT for out_ready. No request is taken while a query runs.
// Reset clears the sequencer and the query state; the stored spans are
// undefined until written.
module swept_box_contact_unit
	import sbc_pkg::*;
#(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    axis,
	input  logic signed [COORD_WIDTH-1:0] box_min,
	input  logic signed [COORD_WIDTH-1:0] box_max,
	input  logic signed [COORD_WIDTH-1:0] obstacle_min,
	input  logic signed [COORD_WIDTH-1:0] obstacle_max,
	input  logic signed [COORD_WIDTH-1:0] velocity,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [FRAC_BITS:0]            hit_time,
	output logic [1:0]                    normal_axis,
	output logic signed [1:0]             normal_sign,
	output logic [1:0]                    result_axis,
	output logic signed [COORD_WIDTH-1:0] contact_coord,
	output logic signed [COORD_WIDTH-1:0] end_min,
	output logic signed [COORD_WIDTH-1:0] end_max,
	output logic                          last
);

	localparam int CW = COORD_WIDTH;
	localparam int PW = CW + FRAC_BITS + 2;
	localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic signed [TIME_W-1:0] T_NEG = {1'b1, {(TIME_W-1){1'b0}}};
	localparam logic signed [TIME_W-1:0] T_ONE = TIME_W'(1) << FRAC_BITS;
	localparam logic signed [CW+1:0] C_HI = (CW+2)'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [CW+1:0] C_LO = -C_HI - 1;

	state_t state_q, state_d;

	logic signed [CW-1:0] sp_bmin_q [3];
	logic signed [CW-1:0] sp_bmax_q [3];
	logic signed [CW-1:0] sp_omin_q [3];
	logic signed [CW-1:0] sp_omax_q [3];
	logic signed [CW-1:0] sp_vel_q  [3];

	logic signed [TIME_W-1:0] entry_q, exit_q, t1_q;
	logic [1:0]               hit_axis_q, hit_sign_q, k_q;
	logic                     sep_q, ovl_q, empty_q;
	status_t                  stat_q;

	logic signed [CW-1:0] bmin, bmax, omin, omax, vel;
	logic                 ovl_all, empty_any;
	logic                 div_start;
	div_ctl_t             div_ctl;
	logic signed [CW:0]   div_num;
	logic signed [TIME_W-1:0] quo, en, ex, new_entry, new_exit;
	logic signed [PW-1:0] prod_q;
	logic signed [CW+1:0] disp, sum_min, sum_max;
	logic signed [CW-1:0] endmin_q, endmax_q, sat_min, sat_max, centre, clamped;
	logic signed [CW:0]   csum;
	logic                 accept_in, accept_out;

	logic                 out_valid_q, last_q;
	logic [1:0]           status_o_q, naxis_o_q, nsign_o_q, raxis_o_q;
	logic [FRAC_BITS:0]   htime_o_q;
	logic signed [CW-1:0] contact_o_q, emin_o_q, emax_o_q;

	logic [1:0] k_idx;
	assign k_idx = k_q;

	assign bmin = sp_bmin_q[k_idx];
	assign bmax = sp_bmax_q[k_idx];
	assign omin = sp_omin_q[k_idx];
	assign omax = sp_omax_q[k_idx];
	assign vel  = sp_vel_q[k_idx];

	assign accept_in  = in_valid && in_ready;
	assign accept_out = out_valid_q && out_ready;

	always_comb begin
		ovl_all   = 1'b1;
		empty_any = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (sp_bmin_q[i] > sp_bmax_q[i]) begin
				empty_any = 1'b1;
			end
			if (sp_bmin_q[i] > sp_bmax_q[i] || sp_omin_q[i] > sp_omax_q[i] ||
			    sp_bmin_q[i] > sp_omax_q[i] || sp_bmax_q[i] < sp_omin_q[i]) begin
				ovl_all = 1'b0;
			end
		end
	end

	assign div_num = (state_q == ST_DIV_A)
	               ? (CW+1)'(omin) - (CW+1)'(bmax)
	               : (CW+1)'(omax) - (CW+1)'(bmin);

	sbc_div #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (vel),
		.ctl    (div_ctl),
		.quo    (quo)
	);

	assign en        = (t1_q < quo) ? t1_q : quo;
	assign ex        = (t1_q < quo) ? quo : t1_q;
	assign new_entry = (en > entry_q) ? en : entry_q;
	assign new_exit  = (ex < exit_q) ? ex : exit_q;

	assign disp    = empty_q ? '0 : (CW+2)'(prod_q >>> FRAC_BITS);
	assign sum_min = (CW+2)'(bmin) + disp;
	assign sum_max = (CW+2)'(bmax) + disp;
	assign sat_min = empty_q ? bmin : (sum_min > C_HI ? CW'(C_HI) :
	                 (sum_min < C_LO ? CW'(C_LO) : CW'(sum_min)));
	assign sat_max = empty_q ? bmax : (sum_max > C_HI ? CW'(C_HI) :
	                 (sum_max < C_LO ? CW'(C_LO) : CW'(sum_max)));
	assign csum    = (CW+1)'(endmin_q) + (CW+1)'(endmax_q);
	assign centre  = CW'(csum >>> 1);

	always_comb begin
		clamped = centre;
		if (clamped > omax) begin
			clamped = omax;
		end
		if (clamped < omin) begin
			clamped = omin;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept_in && axis == AXIS_Z) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK:   state_d = ovl_all ? ST_MUL : ST_AXIS;
			ST_AXIS: begin
				if (sep_q || k_q == AXIS_NONE) begin
					state_d = ST_STATUS;
				end else if (vel != '0) begin
					state_d = ST_DIV_A;
				end
			end
			ST_DIV_A:   state_d = ST_WAIT_A;
			ST_WAIT_A:  state_d = div_ctl.done ? ST_DIV_B : ST_WAIT_A;
			ST_DIV_B:   state_d = ST_WAIT_B;
			ST_WAIT_B:  state_d = div_ctl.done ? ST_UPDATE : ST_WAIT_B;
			ST_UPDATE:  state_d = ST_AXIS;
			ST_STATUS:  state_d = ST_MUL;
			ST_MUL:     state_d = ST_END;
			ST_END:     state_d = ST_CONTACT;
			ST_CONTACT: state_d = ST_OUT;
			ST_OUT: begin
				if (accept_out) begin
					state_d = (k_q == AXIS_Z) ? ST_IDLE : ST_MUL;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_DIV_A) || (state_q == ST_DIV_B);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			entry_q     <= T_NEG;
			exit_q      <= T_MAX;
			hit_axis_q  <= AXIS_X;
			hit_sign_q  <= SIGN_ZERO;
			sep_q       <= 1'b0;
			ovl_q       <= 1'b1;
			empty_q     <= 1'b0;
			k_q         <= AXIS_X;
			stat_q      <= STATUS_MISS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CHECK: begin
					ovl_q   <= ovl_all;
					empty_q <= empty_any;
					k_q     <= AXIS_X;
					if (ovl_all) begin
						stat_q  <= STATUS_OVERLAP;
						entry_q <= '0;
					end
				end
				ST_AXIS: begin
					if (!sep_q && k_q != AXIS_NONE && vel == '0) begin
						if (bmax <= omin || bmin >= omax) begin
							sep_q <= 1'b1;
						end
						k_q <= k_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					if (en > entry_q) begin
						hit_axis_q <= k_q;
						hit_sign_q <= vel[CW-1] ? SIGN_POS : SIGN_NEG;
					end
					entry_q <= new_entry;
					exit_q  <= new_exit;
					if (new_entry > new_exit) begin
						sep_q <= 1'b1;
					end
					k_q <= k_q + 1'b1;
				end
				ST_STATUS: begin
					k_q <= AXIS_X;
					if (sep_q || entry_q < 0 || entry_q > T_ONE || exit_q < 0) begin
						stat_q <= STATUS_MISS;
					end else begin
						stat_q <= STATUS_HIT;
					end
				end
				ST_CONTACT: begin
					out_valid_q <= 1'b1;
				end
				ST_OUT: begin
					if (accept_out) begin
						out_valid_q <= 1'b0;
						k_q         <= k_q + 1'b1;
						if (k_q == AXIS_Z) begin
							entry_q    <= T_NEG;
							exit_q     <= T_MAX;
							hit_axis_q <= AXIS_X;
							hit_sign_q <= SIGN_ZERO;
							sep_q      <= 1'b0;
							ovl_q      <= 1'b1;
							k_q        <= AXIS_X;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in && axis != AXIS_NONE) begin
			sp_bmin_q[axis] <= box_min;
			sp_bmax_q[axis] <= box_max;
			sp_omin_q[axis] <= obstacle_min;
			sp_omax_q[axis] <= obstacle_max;
			sp_vel_q[axis]  <= velocity;
		end
		if (state_q == ST_WAIT_A && div_ctl.done) begin
			t1_q <= quo;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PW'(vel) * PW'($signed({1'b0, entry_q[FRAC_BITS:0]}));
		end
		if (state_q == ST_END) begin
			endmin_q <= sat_min;
			endmax_q <= sat_max;
		end
		if (state_q == ST_CONTACT) begin
			status_o_q <= stat_q;
			raxis_o_q  <= k_q;
			last_q     <= (k_q == AXIS_Z);
			htime_o_q  <= '0;
			naxis_o_q  <= AXIS_X;
			nsign_o_q  <= SIGN_ZERO;
			contact_o_q <= '0;
			emin_o_q   <= '0;
			emax_o_q   <= '0;
			unique case (stat_q)
				STATUS_OVERLAP: begin
					emin_o_q <= bmin;
					emax_o_q <= bmax;
				end
				STATUS_HIT: begin
					htime_o_q   <= entry_q[FRAC_BITS:0];
					naxis_o_q   <= hit_axis_q;
					nsign_o_q   <= hit_sign_q;
					emin_o_q    <= endmin_q;
					emax_o_q    <= endmax_q;
					contact_o_q <= (k_q == hit_axis_q)
					             ? ((hit_sign_q == SIGN_POS) ? omax : omin) : clamped;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_o_q;
	assign hit_time      = htime_o_q;
	assign normal_axis   = naxis_o_q;
	assign normal_sign   = nsign_o_q;
	assign result_axis   = raxis_o_q;
	assign contact_coord = contact_o_q;
	assign end_min       = emin_o_q;
	assign end_max       = emax_o_q;
	assign last          = last_q;

	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_OUT)
		else $error("result shown outside the output state");

	a_no_overlap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid_q))
		else $error("request taken while a result waits");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_ctl.busy)
		else $error("divider started while busy");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> vel != '0)
		else $error("divide by zero velocity");

	a_ovl_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!sep_q && entry_q == T_NEG && ovl_q))
		else $error("query state not cleared");

endmodule

>>> sv/sbc_div.sv
// ----------------------------------------------------------------------------
// Swept box contact time divider
// Restoring divider giving (num << FRAC_BITS) / den toward zero, one
// quotient bit per cycle, with the magnitude saturated to the time range.
// ----------------------------------------------------------------------------
module sbc_div
	import sbc_pkg::*;
#(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_WIDTH:0]   num,
	input  logic signed [COORD_WIDTH-1:0] den,
	output div_ctl_t                      ctl,
	output logic signed [TIME_W-1:0]      quo
);

	localparam int NW    = COORD_WIDTH + 1 + FRAC_BITS;
	localparam int CNT_W = $clog2(NW + 1);
	localparam int SH    = TIME_W - 1 - FRAC_BITS;

	logic [COORD_WIDTH:0]       ud;
	logic [COORD_WIDTH-1:0]     uv;
	logic                       sat_now;
	logic [NW-1:0]              num_q;
	logic [COORD_WIDTH-1:0]     den_q;
	logic [COORD_WIDTH-1:0]     rem_q;
	logic [COORD_WIDTH:0]       trial;
	logic                       bit_ok;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       neg_q;
	logic                       sat_q;
	logic [TIME_W+NW-1:0]       ext;
	logic [TIME_W-1:0]          mag;
	logic signed [TIME_W-1:0]   quo_q;

	assign ud      = num[COORD_WIDTH] ? (COORD_WIDTH+1)'(-num) : num;
	assign uv      = den[COORD_WIDTH-1] ? COORD_WIDTH'(-den) : den;
	assign sat_now = (ud >> SH) >= {1'b0, uv};
	assign trial   = {rem_q, num_q[NW-1]};
	assign bit_ok  = trial >= {1'b0, den_q};
	assign ext     = {{TIME_W{1'b0}}, num_q};
	assign mag     = sat_q ? {1'b0, {(TIME_W-1){1'b1}}} : {1'b0, ext[TIME_W-2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= {ud, {FRAC_BITS{1'b0}}};
			den_q <= uv;
			rem_q <= '0;
			neg_q <= num[COORD_WIDTH] ^ den[COORD_WIDTH-1];
			sat_q <= sat_now;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], bit_ok};
			rem_q <= bit_ok ? COORD_WIDTH'(trial - {1'b0, den_q}) : trial[COORD_WIDTH-1:0];
		end
		if (busy_q && cnt_q == CNT_W'(1)) begin
			quo_q <= '0;
		end
		if (done_q) begin
			quo_q <= neg_q ? -$signed(mag) : $signed(mag);
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign quo       = done_q ? (neg_q ? -$signed(mag) : $signed(mag)) : quo_q;

endmodule
